@@ sv/sitda_pkg.sv @@
// shared types and constants for the signed integer to decimal text converter
package sitda_pkg;

    typedef logic signed [31:0] t_value;
    typedef logic [7:0]         t_char;
    typedef logic [3:0]         t_digit;

    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned DIG_IDX_W  = $clog2(NUM_DIGITS);

    typedef logic [DIG_IDX_W-1:0] t_dig_idx;

    // reciprocal of ten, scaled by 2**35, exact for every 32-bit magnitude
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    localparam t_char ASCII_ZERO  = 8'd48;
    localparam t_char ASCII_MINUS = 8'd45;

endpackage

@@ sv/sitda_if.sv @@
// valid/ready channels for the converter input value and output characters
interface sitda_in_if;
    import sitda_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
    import sitda_pkg::*;

    logic  valid;
    logic  ready;
    t_char character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

@@ sv/signed_int_to_decimal_ascii_top.sv @@
// signed 32-bit integer to decimal ascii text, one character per output request
//
// Takes one signed 32-bit value per input request and returns its decimal text,
// most significant character first: a leading '-' for negative values, then the
// digits, with last set on the final digit; zero gives a single '0'. The most
// negative value comes out as "-2147483648". One value is handled at a time and
// the input is not ready until its last character has been taken. A value is
// accepted, then split into its digits (1..10) one by one on the shared
// divide-by-ten unit (a 32x32 reciprocal multiply that yields quotient and
// remainder together), and then sent one character per output request.
module signed_int_to_decimal_ascii_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sitda_in_if.sink           i_in,
    sitda_out_if.source        o_out
);
    import sitda_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_mag,   n_mag;
    logic        r_neg,   n_neg;
    t_dig_idx    r_cnt,   n_cnt;
    t_digit      r_dig [NUM_DIGITS];

    logic [63:0] w_prod;
    logic [31:0] w_quot;
    t_digit      w_q10_lo;
    t_digit      w_rem;
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_div_done;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    // divide by ten: quotient from the reciprocal product, remainder from low bits only
    assign w_prod     = r_mag * RECIP_TEN;
    assign w_quot     = 32'(w_prod >> RECIP_SHIFT);
    assign w_q10_lo   = {w_quot[0], 3'b000} + {w_quot[2:0], 1'b0};
    assign w_rem      = r_mag[3:0] - w_q10_lo;
    assign w_div_done = (w_quot == 32'd0) || (r_cnt == t_dig_idx'(NUM_DIGITS - 1));

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_SIGN) || (r_state == S_EMIT);
    assign o_out.character   = (r_state == S_SIGN) ? ASCII_MINUS
                                                   : (ASCII_ZERO + t_char'(r_dig[r_cnt]));
    assign o_out.last        = (r_state == S_EMIT) && (r_cnt == '0);

    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_neg   = i_in.value[31];
                    n_mag   = i_in.value[31] ? (32'd0 - 32'(i_in.value)) : 32'(i_in.value);
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_mag = w_quot;
                if (w_div_done) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end else begin
                    n_cnt = r_cnt + t_dig_idx'(1);
                end
            end
            S_SIGN: begin
                if (w_out_acc) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    if (r_cnt == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt - t_dig_idx'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_neg <= n_neg;
    end

    // digits land least significant first, read back from the top down
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV) begin
            r_dig[r_cnt] <= w_rem;
        end
    end

endmodule

@@ sim/signed_int_to_decimal_ascii_top_tb.sv @@
// testbench for the signed integer to decimal ascii converter: random and directed values
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top_tb;
    import sitda_pkg::*;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_text_char;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sitda_in_if  in_ch();
    sitda_out_if out_ch();

    signed_int_to_decimal_ascii_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 i_clk = ~i_clk;

    t_text_char expected_text[$];
    int         errors        = 0;
    int         values_sent   = 0;
    int         negatives     = 0;
    int         chars_checked = 0;
    bit         source_gaps   = 1'b0;
    bit         sink_stalls   = 1'b0;
    int         hold_cycles   = 0;

    // decimal text of one value, most significant character first
    function automatic void push_decimal_text(t_value v);
        logic [31:0] mag;
        t_digit      digs[$];
        t_text_char  c;
        mag = v[31] ? (32'd0 - v) : v;
        do begin
            digs.push_front(t_digit'(mag % 32'd10));
            mag = mag / 32'd10;
        end while (mag != 32'd0);
        if (v[31]) begin
            c.ch   = ASCII_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
            negatives++;
        end
        foreach (digs[k]) begin
            c.ch   = ASCII_ZERO + t_char'(digs[k]);
            c.last = (k == digs.size() - 1);
            expected_text.push_back(c);
        end
    endfunction

    // random value with a given number of decimal digits
    function automatic t_value value_of_length(int ndig, bit neg);
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = (ndig == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
        if (ndig == 1) lo = 0;
        mag = $urandom_range(hi, lo);
        return neg ? t_value'(32'd0 - mag) : t_value'(mag);
    endfunction

    task automatic send_value(input t_value v);
        bit taken;
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        // inputs settle by the falling edge, so the request is taken at the next rising one
        do begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        push_decimal_text(v);
        values_sent++;
    endtask

    // output ready: short random stalls, or a long hold-off when asked
    initial begin : sink_ready
        int n;
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin : text_check
        t_text_char want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_text.size() == 0) begin
                $display("%t unexpected character: expected none, got char %0d last %0b",
                         $time, out_ch.character, out_ch.last);
                errors++;
            end else begin
                want = expected_text.pop_front();
                chars_checked++;
                if (out_ch.character !== want.ch) begin
                    $display("%t character mismatch: expected %0d, got %0d",
                             $time, want.ch, out_ch.character);
                    errors++;
                end
                if (out_ch.last !== want.last) begin
                    $display("%t last flag mismatch: expected %0b, got %0b",
                             $time, want.last, out_ch.last);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        t_value corner[$];
        corner = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                   32'sd99, 32'sd100, 32'sd999999999, -32'sd999999999,
                   32'sd1000000000, -32'sd1000000000, 32'sd2147483647,
                   -32'sd2147483647, 32'sh8000_0000, 32'sh5555_5555,
                   32'shAAAA_AAAA, 32'sd1234567890, -32'sd1023};
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        foreach (corner[k]) send_value(corner[k]);
    endtask

    task automatic test_digit_lengths();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        for (int d = 1; d <= 10; d++) begin
            repeat (2) send_value(value_of_length(d, 1'b0));
            repeat (2) send_value(value_of_length(d, 1'b1));
        end
    endtask

    task automatic test_output_hold_off();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        hold_cycles = 80;
        repeat (8) send_value(value_of_length($urandom_range(1, 10), 1'($urandom_range(0, 1))));
    endtask

    task automatic test_random_values();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        repeat (250) begin
            // a third raw words for bit coverage, the rest spread over text lengths
            if ($urandom_range(0, 2) == 0)
                send_value(t_value'($urandom));
            else
                send_value(value_of_length($urandom_range(1, 10),
                                           1'($urandom_range(0, 1))));
        end
    endtask

    task automatic test_streaming();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        repeat (40) send_value(value_of_length($urandom_range(1, 10), 1'($urandom_range(0, 1))));
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_digit_lengths();
        test_output_hold_off();
        test_random_values();
        test_streaming();

        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("converted %0d values (%0d negative), %0d characters checked",
                 values_sent, negatives, chars_checked);
        $display("idle gaps on both sides, one long output hold-off, then full-rate streaming");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
